// ===== rtl/bgcd_pkg.sv =====
// Shared types and constants for the binary GCD block.
`default_nettype none
package bgcd_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int SHIFT_W = $clog2(DATA_WIDTH + 1);
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [SHIFT_W-1:0] shift_t;

	// Slice operation, broadcast to every bit slice each cycle.
	typedef logic [2:0] op_t;
	localparam op_t OP_HOLD = 3'd0;
	localparam op_t OP_BOTH = 3'd1;
	localparam op_t OP_X    = 3'd2;
	localparam op_t OP_Y    = 3'd3;
	localparam op_t OP_SUB  = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/bgcd_cell.sv =====
// One bit slice of the GCD datapath: holds one bit of x and y, passes both borrow chains.
`default_nettype none
module bgcd_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic a_bit,
	input  wire logic b_bit,
	input  wire bgcd_pkg::op_t op,
	input  wire logic x_up,
	input  wire logic y_up,
	input  wire logic swap,
	input  wire logic bxy_in,
	input  wire logic byx_in,
	output logic x_bit,
	output logic y_bit,
	output logic bxy_out,
	output logic byx_out
);
	import bgcd_pkg::*;

	logic x_q, y_q, d_yx, d_xy;

	// y - x and x - y ripple side by side from the lsb
	assign d_yx = y_q ^ x_q ^ bxy_in;
	assign bxy_out = (~y_q & x_q) | (~(y_q ^ x_q) & bxy_in);
	assign d_xy = x_q ^ y_q ^ byx_in;
	assign byx_out = (~x_q & y_q) | (~(x_q ^ y_q) & byx_in);

	assign x_bit = x_q;
	assign y_bit = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= 1'b0;
			y_q <= 1'b0;
		end else if (load) begin
			x_q <= a_bit;
			y_q <= b_bit;
		end else begin
			case (op)
				OP_BOTH: begin
					x_q <= x_up;
					y_q <= y_up;
				end
				OP_X: x_q <= x_up;
				OP_Y: y_q <= y_up;
				// swap: x > y, so x takes y and y takes x - y
				OP_SUB: begin
					x_q <= swap ? y_q : x_q;
					y_q <= swap ? d_xy : d_yx;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/binary_gcd.sv =====
// Top level of the binary GCD block: control sequencer and row of bit-slice cells.
//
// Usage: a request on operand_a/operand_b with in_valid is taken when in_stall is
// low; in_stall is high whenever a request is in flight. One divisor is returned
// per request on divisor with out_valid; the receiver holds it with out_stall,
// and the result stays stable meanwhile.
// Sequence from the accepting edge: shared factors of two are stripped from both
// operands and counted, then x is halved to odd, then y is halved to odd and
// subtracted until y is zero; the result, shifted back left, is then presented.
// Zero operands bypass the loop: the result is the other operand.
// The time taken is set by the total count of halvings and subtracts, done one
// per cycle in the slice row.
// Throughput: one request at a time; the next is taken the cycle after the
// previous result has been handed over.
// Reset (arst_n low) clears the sequencer and the slices and drops out_valid;
// any request in flight is lost. While out_stall is high the result holds.
`default_nettype none
module binary_gcd (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire bgcd_pkg::data_t operand_a,
	input  wire bgcd_pkg::data_t operand_b,
	output logic out_valid,
	input  wire logic out_stall,
	output bgcd_pkg::data_t divisor
);
	import bgcd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TWOS = 3'd1;
	localparam logic [2:0] ST_XODD = 3'd2;
	localparam logic [2:0] ST_LOOP = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	shift_t twos_q;
	data_t res_q;
	logic accept, swap;
	op_t op;
	data_t x, y;
	logic [DATA_WIDTH:0] bxy, byx;

	// only idle takes a request
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	// both borrow chains enter at the lsb; y - x borrowing out means x > y
	assign bxy[0] = 1'b0;
	assign byx[0] = 1'b0;
	assign swap = bxy[DATA_WIDTH];

	genvar i;
	generate
		for (i = 0; i < DATA_WIDTH; i++) begin : g_cell
			logic xu, yu;
			// right shift: each slice takes its upper neighbor, the top takes zero
			if (i == DATA_WIDTH - 1) begin : g_top
				assign xu = 1'b0;
				assign yu = 1'b0;
			end else begin : g_mid
				assign xu = x[i+1];
				assign yu = y[i+1];
			end
			bgcd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .load(accept),
				.a_bit(operand_a[i]), .b_bit(operand_b[i]),
				.op(op), .x_up(xu), .y_up(yu), .swap(swap),
				.bxy_in(bxy[i]), .byx_in(byx[i]),
				.x_bit(x[i]), .y_bit(y[i]),
				.bxy_out(bxy[i+1]), .byx_out(byx[i+1])
			);
		end
	endgenerate

	// slice operation for this cycle
	always_comb begin
		op = OP_HOLD;
		case (state_q)
			ST_TWOS: op = (x != '0 && y != '0 && !x[0] && !y[0]) ? OP_BOTH : OP_HOLD;
			ST_XODD: op = !x[0] ? OP_X : OP_HOLD;
			ST_LOOP: op = (y == '0) ? OP_HOLD : (!y[0] ? OP_Y : OP_SUB);
			default: op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			twos_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_TWOS;
						twos_q <= '0;
					end
				end
				// zero operand: the other one is the answer
				ST_TWOS: begin
					if (x == '0) begin
						res_q <= y;
						state_q <= ST_DONE;
					end else if (y == '0) begin
						res_q <= x;
						state_q <= ST_DONE;
					end else if (!x[0] && !y[0]) begin
						twos_q <= twos_q + 1'b1;
					end else begin
						state_q <= ST_XODD;
					end
				end
				ST_XODD: begin
					if (x[0])
						state_q <= ST_LOOP;
				end
				// halve y to odd, then swap/subtract, until y reaches zero
				ST_LOOP: begin
					if (y == '0) begin
						res_q <= data_t'(x << twos_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == ST_DONE);
	assign divisor = res_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(divisor)) else $error("result lost");
	a_twos: assert property (@(posedge clk) disable iff (!arst_n)
		twos_q < DATA_WIDTH) else $error("twos overflow");
	a_borrow: assert property (@(posedge clk) disable iff (!arst_n)
		!(bxy[DATA_WIDTH] && byx[DATA_WIDTH])) else $error("both borrows set");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/gcd_checker.sv =====
// Checker for the binary GCD block: watches both channels, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module gcd_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire bgcd_pkg::data_t operand_a,
	input  wire bgcd_pkg::data_t operand_b,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire bgcd_pkg::data_t divisor,
	output int errors,
	output int pending
);
	import bgcd_pkg::*;

	data_t gcd_queue[$];

	// Stein's method, same steps as the block
	function automatic data_t stein_gcd(data_t x, data_t y);
		int twos;
		data_t t;
		twos = 0;
		if (x == '0) return y;
		if (y == '0) return x;
		while (((x | y) & 1) == 0) begin
			x = x >> 1;
			y = y >> 1;
			twos++;
		end
		while (x[0] == 1'b0) x = x >> 1;
		do begin
			while (y[0] == 1'b0) y = y >> 1;
			if (x > y) begin
				t = x;
				x = y;
				y = t;
			end
			y = y - x;
		end while (y != '0);
		return data_t'(x << twos);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	initial errors = 0;
	assign pending = gcd_queue.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				gcd_queue.push_back(stein_gcd(operand_a, operand_b));
			if (out_valid && !out_stall) begin
				if (gcd_queue.size() == 0)
					report_mismatch($sformatf("unexpected divisor %h", divisor));
				else if (gcd_queue[0] !== divisor) begin
					report_mismatch($sformatf("divisor %h, expected %h",
						divisor, gcd_queue[0]));
					void'(gcd_queue.pop_front());
				end else
					void'(gcd_queue.pop_front());
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Top of the binary GCD testbench: stimulus, idling phases and the verdict.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import bgcd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	data_t operand_a = '0;
	data_t operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	data_t divisor;
	int errors;
	int pending;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic long_hold = 1'b0;
	int sent = 0;
	event hold_go;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	binary_gcd u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .divisor(divisor)
	);

	gcd_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .divisor(divisor), .errors(errors), .pending(pending)
	);

	// Watchdog: limit covers the worst case of every request plus stalls, many times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Long receiver hold-off, counted here
	always begin
		@(hold_go);
		long_hold <= 1'b1;
		repeat (400) @(negedge clk);
		long_hold <= 1'b0;
	end

	// Receiver: random stall, or the long hold-off
	always @(negedge clk) begin
		out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
	end

	// Operand with varied shape: shared powers of two, small values, full width
	function automatic data_t rand_operand(int shift);
		data_t v;
		case ($urandom_range(5))
			0: v = $urandom;
			1: v = $urandom_range(255);
			2: v = data_t'($urandom) >> $urandom_range(31);
			3: v = '0;
			default: v = data_t'($urandom_range(65535)) | 32'h1;
		endcase
		return data_t'(v << shift);
	endfunction

	// One request; the idle gap comes first, then valid holds until accepted
	task automatic send_request(input data_t a, input data_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic random_phase(input int count, input int idle, input int stall);
		int shift;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) begin
			shift = ($urandom_range(3) == 0) ? $urandom_range(31) : 0;
			if ($urandom_range(19) == 0)
				send_request(data_t'($urandom), data_t'($urandom));
			else
				send_request(rand_operand(shift), rand_operand(shift));
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed: zeros, extremes, powers of two, equal and coprime operands
		send_request(32'h0, 32'h0);
		send_request(32'h0, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'h0);
		send_request(32'h0, 32'h8000_0000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'h8000_0000, 32'h8000_0000);
		send_request(32'h8000_0000, 32'h4000_0000);
		send_request(32'h8000_0000, 32'h1);
		send_request(32'h1, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_request(32'hAAAA_AAAA, 32'h5555_5555);
		send_request(32'hFFFF_FFFB, 32'hFFFF_FFF1);
		send_request(32'd48, 32'd18);
		send_request(32'd1071, 32'd462);
		send_request(32'hB504_F334, 32'h6A09_E668);
		send_request(32'h1, 32'h1);
		send_request(32'h7FFF_FFFF, 32'h8000_0000);
		// Random phases with differing idle and stall rates
		random_phase(400, 0, 0);
		random_phase(400, 77, 0);
		random_phase(400, 0, 77);
		random_phase(350, 29, 29);
		// Long receiver hold-off while requests keep coming
		-> hold_go;
		random_phase(80, 0, 0);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (2 * DATA_WIDTH + 10) @(posedge clk);
		$display("Sent %0d requests over idle/stall phases and a long receiver hold-off.",
			sent);
		$display("Covered zero operands, full-width extremes and shared powers of two.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ===== binary_gcd.f =====
rtl/bgcd_pkg.sv
rtl/bgcd_cell.sv
rtl/binary_gcd.sv
tb/sv/gcd_checker.sv
tb/sv/testbench.sv
